[rtl/grf_pkg.sv]
// Shared codes and widths for the growable record FIFO.
`timescale 1ns / 1ps
`default_nettype none

package grf_pkg;

    localparam int unsigned CFG_W   = 7;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_INIT_CAP  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GROW_STEP = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CAP_LIMIT = 2'd2;

endpackage

`default_nettype wire

[rtl/growable_record_fifo.sv]
// Top level of the growable record FIFO: slot ring, byte and length memories, pop streamer.
`timescale 1ns / 1ps
`default_nettype none

// A push request gives its result on the cycle after start is taken, and pushes may follow
// back to back. A pop request holds busy while the S_LEN state reads the length memory and
// then while the byte memory delivers one byte per cycle, each result showing on the strobe
// in the cycle after its read. An empty pop gives one result. Results cannot be stalled;
// every strobe is one result. Configuration writes are always ready and are meant for idle
// periods. No clearing pass runs after reset.
module growable_record_fifo #(
    parameter int unsigned MAX_RECORDS  = 64,
    parameter int unsigned RECORD_BYTES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [grf_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_last_byte,
    output logic                               o_strobe,
    output logic [grf_pkg::STAT_W-1:0]         o_status,
    output logic [grf_pkg::BYTE_W-1:0]         o_data_out,
    output logic                               o_last_out,
    output logic [grf_pkg::CFG_W-1:0]          o_record_length,
    output logic [grf_pkg::CFG_W-1:0]          o_record_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [grf_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [grf_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
    localparam int unsigned SW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned OW = $clog2(RECORD_BYTES + 1);
    localparam int unsigned GW = ((CW > grf_pkg::CFG_W) ? CW : grf_pkg::CFG_W) + 1;
    localparam int unsigned DEPTH = MAX_RECORDS * RECORD_BYTES;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM
    } t_state;

    logic [grf_pkg::BYTE_W-1:0] r_byte_mem [DEPTH];
    logic [OW-1:0]              r_len_mem  [MAX_RECORDS];
    logic [grf_pkg::BYTE_W-1:0] r_byte_rdata;
    logic [OW-1:0]              r_len_rdata;

    t_state                     r_state, n_state;
    logic [SW-1:0]              r_head, n_head;
    logic [SW-1:0]              r_tail, n_tail;
    logic [SW-1:0]              r_pop_slot, n_pop_slot;
    logic [CW-1:0]              r_stored, n_stored;
    logic [CW-1:0]              r_alloc, n_alloc;
    logic                       r_open, n_open;
    logic                       r_rej, n_rej;
    logic [OW-1:0]              r_off, n_off;
    logic [OW-1:0]              r_len, n_len;
    logic [OW-1:0]              r_rd_off, n_rd_off;
    logic [OW-1:0]              r_out_idx, n_out_idx;
    logic [grf_pkg::CFG_W-1:0]  r_init_cap, n_init_cap;
    logic [grf_pkg::CFG_W-1:0]  r_step, n_step;
    logic [grf_pkg::CFG_W-1:0]  r_limit, n_limit;
    logic                       r_strobe, n_strobe;
    logic [grf_pkg::STAT_W-1:0] r_status, n_status;
    logic [grf_pkg::BYTE_W-1:0] r_data, n_data;
    logic                       r_last, n_last;
    logic [OW-1:0]              r_len_out, n_len_out;

    logic                       accept;
    logic                       has_room;
    logic                       can_grow;
    logic [GW-1:0]              grown;
    logic                       rej_eff;
    logic [OW-1:0]              off_eff;
    logic                       wr_en;
    logic                       len_wr_en;
    logic [OW-1:0]              len_wdata;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [OW-1:0]              rd_off_sel;
    logic [OW-1:0]              len_clamped;
    logic [GW-1:0]              cfg_ext;
    logic [CW-1:0]              cap_clamped;
    logic [GW-1:0]              count_ext;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_data_out      = r_data;
    assign o_last_out      = r_last;
    assign o_record_length = grf_pkg::CFG_W'(r_len_out);
    assign count_ext       = GW'(r_stored);
    assign o_record_count  = count_ext[grf_pkg::CFG_W-1:0];

    assign has_room = (r_stored < r_alloc);
    assign grown    = GW'(r_alloc) + GW'(r_step);
    assign can_grow = (r_step != '0) && (grown <= GW'(r_limit))
                      && (grown <= GW'(MAX_RECORDS));

    assign cfg_ext     = GW'(i_cfg_data);
    assign cap_clamped = (cfg_ext == '0) ? CW'(1)
                       : (cfg_ext > GW'(MAX_RECORDS)) ? CW'(MAX_RECORDS)
                       : CW'(cfg_ext);

    assign len_clamped = (r_len_rdata == '0) ? OW'(1)
                       : (r_len_rdata > OW'(RECORD_BYTES)) ? OW'(RECORD_BYTES)
                       : r_len_rdata;

    assign rd_off_sel = (r_state == S_STREAM && r_rd_off < r_len) ? r_rd_off : '0;
    assign rd_addr    = AW'(r_pop_slot) * AW'(RECORD_BYTES) + AW'(rd_off_sel);
    assign wr_addr    = AW'(r_tail) * AW'(RECORD_BYTES) + AW'(off_eff);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_pop_slot = r_pop_slot;
        n_stored   = r_stored;
        n_alloc    = r_alloc;
        n_open     = r_open;
        n_rej      = r_rej;
        n_off      = r_off;
        n_len      = r_len;
        n_rd_off   = r_rd_off;
        n_out_idx  = r_out_idx;
        n_init_cap = r_init_cap;
        n_step     = r_step;
        n_limit    = r_limit;
        n_strobe   = 1'b0;
        n_status   = grf_pkg::ST_OK;
        n_data     = '0;
        n_last     = 1'b1;
        n_len_out  = '0;
        wr_en      = 1'b0;
        len_wr_en  = 1'b0;
        len_wdata  = '0;
        rej_eff    = r_rej;
        off_eff    = r_off;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                grf_pkg::CFG_INIT_CAP: begin
                    n_init_cap = i_cfg_data;
                    if (r_stored == '0 && !r_open) begin
                        n_alloc = cap_clamped;
                    end
                end
                grf_pkg::CFG_GROW_STEP: n_step  = i_cfg_data;
                grf_pkg::CFG_CAP_LIMIT: n_limit = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == grf_pkg::OP_PUSH) begin
                    n_strobe = 1'b1;
                    if (!r_open) begin
                        off_eff = '0;
                        rej_eff = !(has_room || can_grow);
                        if (!has_room && can_grow) begin
                            n_alloc = CW'(grown);
                        end
                    end
                    n_off = off_eff;
                    if (rej_eff) begin
                        n_status = grf_pkg::ST_REJECT;
                    end else if (off_eff < OW'(RECORD_BYTES)) begin
                        wr_en = 1'b1;
                        n_off = off_eff + 1'b1;
                    end else begin
                        n_status = grf_pkg::ST_TOO_LONG;
                    end
                    len_wdata = n_off;
                    if (i_last_byte) begin
                        if (!rej_eff) begin
                            len_wr_en = 1'b1;
                            n_tail   = (r_tail == SW'(MAX_RECORDS - 1)) ? '0 : r_tail + 1'b1;
                            n_stored = r_stored + 1'b1;
                        end
                        n_open = 1'b0;
                        n_rej  = 1'b0;
                        n_off  = '0;
                    end else begin
                        n_open = 1'b1;
                        n_rej  = rej_eff;
                    end
                end else if (accept) begin
                    if (r_stored == '0) begin
                        n_strobe = 1'b1;
                        n_status = grf_pkg::ST_EMPTY;
                    end else begin
                        n_pop_slot = r_head;
                        n_head     = (r_head == SW'(MAX_RECORDS - 1)) ? '0 : r_head + 1'b1;
                        n_stored   = r_stored - 1'b1;
                        n_state    = S_LEN;
                    end
                end
            end
            S_LEN: begin
                n_len     = len_clamped;
                n_rd_off  = OW'(1);
                n_out_idx = '0;
                n_state   = S_STREAM;
            end
            S_STREAM: begin
                n_strobe  = 1'b1;
                n_data    = r_byte_rdata;
                n_len_out = r_len;
                n_last    = ((OW + 1)'(r_out_idx) + 1'b1 == (OW + 1)'(r_len));
                n_out_idx = r_out_idx + 1'b1;
                if (r_rd_off < r_len) begin
                    n_rd_off = r_rd_off + 1'b1;
                end
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_byte_mem[wr_addr] <= i_data_byte;
        end
        if (len_wr_en) begin
            r_len_mem[r_tail] <= len_wdata;
        end
        r_byte_rdata <= r_byte_mem[rd_addr];
        r_len_rdata  <= r_len_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_stored   <= '0;
            r_alloc    <= (MAX_RECORDS < 8) ? CW'(MAX_RECORDS) : CW'(8);
            r_open     <= 1'b0;
            r_rej      <= 1'b0;
            r_off      <= '0;
            r_init_cap <= grf_pkg::CFG_W'(8);
            r_step     <= grf_pkg::CFG_W'(8);
            r_limit    <= grf_pkg::CFG_W'(64);
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_stored   <= n_stored;
            r_alloc    <= n_alloc;
            r_open     <= n_open;
            r_rej      <= n_rej;
            r_off      <= n_off;
            r_init_cap <= n_init_cap;
            r_step     <= n_step;
            r_limit    <= n_limit;
            r_strobe   <= n_strobe;
        end
        r_pop_slot <= n_pop_slot;
        r_len      <= n_len;
        r_rd_off   <= n_rd_off;
        r_out_idx  <= n_out_idx;
        r_status   <= n_status;
        r_data     <= n_data;
        r_last     <= n_last;
        r_len_out  <= n_len_out;
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the growable record FIFO: queued push/pop requests and register writes.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_REC     = 64;
    localparam int REC_BYTES   = 64;
    localparam int ITEM_TARGET = 310;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;

    localparam logic [grf_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        REQ_FIFO,
        REQ_REG,
        REQ_DRAIN
    } t_req_kind;

    typedef struct {
        t_req_kind                     kind;
        logic                          op;
        logic [grf_pkg::BYTE_W-1:0]    data;
        logic                          last;
        logic [grf_pkg::CIDX_W-1:0]    idx;
        logic [grf_pkg::CFG_W-1:0]     val;
    } t_fifo_req;

    typedef struct packed {
        logic [grf_pkg::STAT_W-1:0]    status;
        logic [grf_pkg::BYTE_W-1:0]    data;
        logic                          last;
        logic [grf_pkg::CFG_W-1:0]     length;
        logic [grf_pkg::CFG_W-1:0]     count;
    } t_fifo_out;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_operation = grf_pkg::OP_PUSH;
    logic [grf_pkg::BYTE_W-1:0]    i_data_byte = '0;
    logic                          i_last_byte = 1'b0;
    logic                          o_strobe;
    logic [grf_pkg::STAT_W-1:0]    o_status;
    logic [grf_pkg::BYTE_W-1:0]    o_data_out;
    logic                          o_last_out;
    logic [grf_pkg::CFG_W-1:0]     o_record_length;
    logic [grf_pkg::CFG_W-1:0]     o_record_count;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [grf_pkg::CIDX_W-1:0]    i_cfg_index = '0;
    logic [grf_pkg::CFG_W-1:0]     i_cfg_data = '0;

    growable_record_fifo u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_last_out      (o_last_out),
        .o_record_length (o_record_length),
        .o_record_count  (o_record_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_fifo_req pending[$];
    t_fifo_out fifo_out_q[$];
    int        n_items = 0;
    int        n_predicted = 0;
    int        n_checked = 0;
    int        err_count = 0;
    int        stall_cycles = 0;
    int        hold_off = 0;
    int        burst_left = 0;

    // Shadow state of the FIFO
    logic [grf_pkg::BYTE_W-1:0] rec_mem [MAX_REC][REC_BYTES];
    logic [grf_pkg::CFG_W-1:0]  len_mem [MAX_REC];
    logic [5:0]                 m_head;
    logic [5:0]                 m_tail;
    logic [grf_pkg::CFG_W-1:0]  m_stored;
    logic [grf_pkg::CFG_W-1:0]  m_alloc;
    logic [grf_pkg::CFG_W-1:0]  m_woff;
    logic                       m_open;
    logic                       m_rejecting;
    logic [grf_pkg::CFG_W-1:0]  m_init_cap;
    logic [grf_pkg::CFG_W-1:0]  m_step;
    logic [grf_pkg::CFG_W-1:0]  m_limit;

    function automatic logic [grf_pkg::CFG_W-1:0] clamp_slots(
            input logic [grf_pkg::CFG_W-1:0] v);
        if (v < 1) return 7'd1;
        if (v > MAX_REC) return 7'(MAX_REC);
        return v;
    endfunction

    function automatic void reset_fifo_model();
        m_head      = '0;
        m_tail      = '0;
        m_stored    = '0;
        m_woff      = '0;
        m_open      = 1'b0;
        m_rejecting = 1'b0;
        m_init_cap  = 7'd8;
        m_step      = 7'd8;
        m_limit     = 7'd64;
        m_alloc     = clamp_slots(m_init_cap);
    endfunction

    function automatic void write_fifo_register(input logic [grf_pkg::CIDX_W-1:0] idx,
                                                input logic [grf_pkg::CFG_W-1:0] v);
        case (idx)
            grf_pkg::CFG_INIT_CAP: begin
                m_init_cap = v;
                if (m_stored == 0 && !m_open) m_alloc = clamp_slots(v);
            end
            grf_pkg::CFG_GROW_STEP: m_step = v;
            grf_pkg::CFG_CAP_LIMIT: m_limit = v;
            default: ;
        endcase
    endfunction

    function automatic void predict_fifo_request(input logic op,
                                                 input logic [grf_pkg::BYTE_W-1:0] data,
                                                 input logic last);
        t_fifo_out                 r;
        int                        grown;
        int                        i;
        logic [grf_pkg::CFG_W-1:0] len;
        logic [5:0]                slot;
        r = '0;
        if (op == grf_pkg::OP_PUSH) begin
            r.status = grf_pkg::ST_OK;
            if (!m_open) begin
                m_open      = 1'b1;
                m_woff      = '0;
                m_rejecting = 1'b0;
                if (m_stored >= m_alloc) begin
                    grown = int'(m_alloc) + int'(m_step);
                    if (m_step != 0 && grown <= int'(m_limit) && grown <= MAX_REC)
                        m_alloc = 7'(grown);
                    else
                        m_rejecting = 1'b1;
                end
            end
            if (m_rejecting) begin
                r.status = grf_pkg::ST_REJECT;
            end else if (m_woff < REC_BYTES) begin
                rec_mem[m_tail][m_woff[5:0]] = data;
                m_woff = m_woff + 7'd1;
            end else begin
                r.status = grf_pkg::ST_TOO_LONG;
            end
            if (last) begin
                if (!m_rejecting) begin
                    len_mem[m_tail] = m_woff;
                    m_tail   = m_tail + 6'd1;
                    m_stored = m_stored + 7'd1;
                end
                m_open      = 1'b0;
                m_rejecting = 1'b0;
                m_woff      = '0;
            end
            r.last  = 1'b1;
            r.count = m_stored;
            fifo_out_q.push_back(r);
            n_predicted++;
        end else if (m_stored == 0) begin
            r.status = grf_pkg::ST_EMPTY;
            r.last   = 1'b1;
            fifo_out_q.push_back(r);
            n_predicted++;
        end else begin
            slot = m_head;
            len  = len_mem[slot];
            if (len < 1) len = 7'd1;
            if (len > REC_BYTES) len = 7'(REC_BYTES);
            m_head   = m_head + 6'd1;
            m_stored = m_stored - 7'd1;
            for (i = 0; i < int'(len); i++) begin
                r.status = grf_pkg::ST_OK;
                r.data   = rec_mem[slot][i];
                r.last   = (i + 1 == int'(len));
                r.length = len;
                r.count  = m_stored;
                fifo_out_q.push_back(r);
                n_predicted++;
            end
        end
    endfunction

    function automatic void add_push(input logic [grf_pkg::BYTE_W-1:0] data, input logic last);
        t_fifo_req q;
        q = '{kind: REQ_FIFO, op: grf_pkg::OP_PUSH, data: data, last: last, idx: '0, val: '0};
        pending.push_back(q);
        n_items++;
    endfunction

    function automatic void add_pop();
        t_fifo_req q;
        q = '{kind: REQ_FIFO, op: grf_pkg::OP_POP, data: 8'($urandom_range(0, 255)),
              last: 1'($urandom_range(0, 1)), idx: '0, val: '0};
        pending.push_back(q);
        n_items++;
    endfunction

    function automatic void add_reg(input logic [grf_pkg::CIDX_W-1:0] idx,
                                    input logic [grf_pkg::CFG_W-1:0] v);
        t_fifo_req q;
        q = '{kind: REQ_REG, op: grf_pkg::OP_PUSH, data: '0, last: 1'b0, idx: idx, val: v};
        pending.push_back(q);
    endfunction

    function automatic void add_drain();
        t_fifo_req q;
        q = '{kind: REQ_DRAIN, op: grf_pkg::OP_PUSH, data: '0, last: 1'b0, idx: '0, val: '0};
        pending.push_back(q);
    endfunction

    // Push one record; now and then pop while it is still open
    function automatic void add_record(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 11) == 0) add_pop();
            add_push(8'($urandom_range(0, 255)), k == len - 1);
        end
    endfunction

    function automatic logic [grf_pkg::CFG_W-1:0] reg_pick();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_operation <= grf_pkg::OP_PUSH;
            i_data_byte <= '0;
            i_last_byte <= 1'b0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data  <= '0;
            hold_off    = 0;
            burst_left  = 0;
            n_predicted = 0;
            fifo_out_q.delete();
            reset_fifo_model();
        end else begin
            if (start && !busy) begin
                predict_fifo_request(i_operation, i_data_byte, i_last_byte);
                if (burst_left > 0) begin
                    burst_left--;
                    hold_off = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    burst_left = $urandom_range(10, 40);
                    hold_off   = 0;
                end else begin
                    hold_off = $urandom_range(0, 6);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_fifo_register(i_cfg_index, i_cfg_data);
                void'(pending.pop_front());
            end
            if ((start && busy) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the current request
            end else if (hold_off > 0) begin
                hold_off--;
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else begin
                case (pending[0].kind)
                    REQ_FIFO: begin
                        start       <= 1'b1;
                        i_operation <= pending[0].op;
                        i_data_byte <= pending[0].data;
                        i_last_byte <= pending[0].last;
                        i_cfg_valid <= 1'b0;
                        void'(pending.pop_front());
                    end
                    REQ_REG: begin
                        start <= 1'b0;
                        if (n_predicted == n_checked && !busy && !start) begin
                            i_cfg_valid <= 1'b1;
                            i_cfg_index <= pending[0].idx;
                            i_cfg_data  <= pending[0].val;
                        end else begin
                            i_cfg_valid <= 1'b0;
                        end
                    end
                    default: begin
                        start       <= 1'b0;
                        i_cfg_valid <= 1'b0;
                        if (n_predicted == n_checked && !busy && !start)
                            void'(pending.pop_front());
                    end
                endcase
            end
        end
    end

    // Result monitor and watchdog
    always @(posedge i_clk) begin
        t_fifo_out got;
        t_fifo_out want;
        if (!i_rst_n) begin
            n_checked    <= 0;
            stall_cycles <= 0;
        end else begin
            if (o_strobe) begin
                got = {o_status, o_data_out, o_last_out, o_record_length, o_record_count};
                if (fifo_out_q.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result st=%0d d=%02h last=%0d len=%0d cnt=%0d",
                             $time, got.status, got.data, got.last, got.length, got.count);
                end else begin
                    want = fifo_out_q.pop_front();
                    n_checked <= n_checked + 1;
                    if (got.status !== want.status || got.data !== want.data ||
                        got.last !== want.last || got.length !== want.length ||
                        got.count !== want.count) begin
                        err_count++;
                        $display("%0t mismatch exp st=%0d d=%02h last=%0d len=%0d cnt=%0d",
                                 $time, want.status, want.data, want.last, want.length,
                                 want.count);
                        $display("%0t          act st=%0d d=%02h last=%0d len=%0d cnt=%0d",
                                 $time, got.status, got.data, got.last, got.length,
                                 got.count);
                    end
                end
            end
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog expired", $time);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int pop_pct;
        int len;

        // empty pop, byte extremes, pop during an open push
        add_pop();
        add_push(8'h00, 1'b1);
        add_push(8'hFF, 1'b1);
        add_push(8'hA5, 1'b0);
        add_pop();
        add_push(8'h5A, 1'b1);
        add_pop();
        add_pop();
        add_pop();

        // zero grow step rejects a record once the single slot is taken
        add_drain();
        add_reg(grf_pkg::CFG_INIT_CAP, 7'd1);
        add_reg(grf_pkg::CFG_GROW_STEP, 7'd0);
        add_push(8'h11, 1'b1);
        add_push(8'h22, 1'b0);
        add_push(8'h33, 1'b1);
        add_pop();
        add_pop();

        // growth up to the limit, then rejection
        add_drain();
        add_reg(grf_pkg::CFG_INIT_CAP, 7'd2);
        add_reg(grf_pkg::CFG_GROW_STEP, 7'd3);
        add_reg(grf_pkg::CFG_CAP_LIMIT, 7'd5);
        repeat (6) add_push(8'($urandom_range(0, 255)), 1'b1);

        // capacity write while records are stored, unused index, zero limit
        add_drain();
        add_reg(grf_pkg::CFG_INIT_CAP, 7'd0);
        add_reg(CFG_UNUSED, 7'd127);
        add_reg(grf_pkg::CFG_CAP_LIMIT, 7'd0);
        add_push(8'h7E, 1'b1);
        repeat (6) add_pop();

        // oversized record
        add_drain();
        add_reg(grf_pkg::CFG_CAP_LIMIT, 7'd64);
        add_record(66);
        add_pop();

        while (n_items < ITEM_TARGET) begin
            add_drain();
            add_reg(grf_pkg::CFG_INIT_CAP, reg_pick());
            add_reg(grf_pkg::CFG_GROW_STEP, reg_pick());
            add_reg(grf_pkg::CFG_CAP_LIMIT, reg_pick());
            if ($urandom_range(0, 3) == 0) add_reg(CFG_UNUSED, 7'($urandom_range(0, 127)));
            case ($urandom_range(0, 2))
                0: pop_pct = 10;
                1: pop_pct = 35;
                default: pop_pct = 70;
            endcase
            repeat ($urandom_range(8, 20)) begin
                if ($urandom_range(0, 99) < pop_pct) begin
                    add_pop();
                end else begin
                    len = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 66)
                                                       : $urandom_range(1, 4);
                    add_record(len);
                end
                if ($urandom_range(0, 15) == 0) add_drain();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending.size() != 0 || start || i_cfg_valid || n_predicted != n_checked);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0 && fifo_out_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
